// File: rtl/core/msae_pkg.sv
`timescale 1ns / 1ps
package msae_pkg;

  // Function codes of the SPECIAL group
  localparam logic [5:0] F_SLL     = 6'h00;
  localparam logic [5:0] F_SRL     = 6'h02;
  localparam logic [5:0] F_SRA     = 6'h03;
  localparam logic [5:0] F_SLLV    = 6'h04;
  localparam logic [5:0] F_SRLV    = 6'h06;
  localparam logic [5:0] F_SRAV    = 6'h07;
  localparam logic [5:0] F_JR      = 6'h08;
  localparam logic [5:0] F_JALR    = 6'h09;
  localparam logic [5:0] F_MOVZ    = 6'h0A;
  localparam logic [5:0] F_MOVN    = 6'h0B;
  localparam logic [5:0] F_SYSCALL = 6'h0C;
  localparam logic [5:0] F_SYNC    = 6'h0F;
  localparam logic [5:0] F_MFHI    = 6'h10;
  localparam logic [5:0] F_MFLO    = 6'h12;
  localparam logic [5:0] F_DSLLV   = 6'h14;
  localparam logic [5:0] F_DSRLV   = 6'h16;
  localparam logic [5:0] F_DSRAV   = 6'h17;
  localparam logic [5:0] F_MULT    = 6'h18;
  localparam logic [5:0] F_MULTU   = 6'h19;
  localparam logic [5:0] F_DIV     = 6'h1A;
  localparam logic [5:0] F_DIVU    = 6'h1B;
  localparam logic [5:0] F_ADD     = 6'h20;
  localparam logic [5:0] F_ADDU    = 6'h21;
  localparam logic [5:0] F_SUB     = 6'h22;
  localparam logic [5:0] F_SUBU    = 6'h23;
  localparam logic [5:0] F_AND     = 6'h24;
  localparam logic [5:0] F_OR      = 6'h25;
  localparam logic [5:0] F_XOR     = 6'h26;
  localparam logic [5:0] F_NOR     = 6'h27;
  localparam logic [5:0] F_MFSA    = 6'h28;
  localparam logic [5:0] F_SLT     = 6'h2A;
  localparam logic [5:0] F_SLTU    = 6'h2B;
  localparam logic [5:0] F_DADD    = 6'h2C;
  localparam logic [5:0] F_DADDU   = 6'h2D;
  localparam logic [5:0] F_DSUB    = 6'h2E;
  localparam logic [5:0] F_DSUBU   = 6'h2F;
  localparam logic [5:0] F_DSLL    = 6'h38;
  localparam logic [5:0] F_DSRL    = 6'h3A;
  localparam logic [5:0] F_DSLL32  = 6'h3C;
  localparam logic [5:0] F_DSRL32  = 6'h3E;
  localparam logic [5:0] F_DSRA32  = 6'h3F;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SYSCALL = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  localparam int DivSteps = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DIVFIX,
    S_DONE
  } state_t;

  // Sequencer to divider control
  typedef struct packed {
    logic start;
    logic is_signed;
  } div_ctl_t;

  function automatic logic [63:0] sext32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

endpackage

// File: rtl/core/msae_div.sv
`timescale 1ns / 1ps
// Radix-2 restoring divider: one quotient bit per cycle
module msae_div (
  input  logic                clk,
  input  logic                rst,
  input  msae_pkg::div_ctl_t  ctl,
  input  logic [31:0]         dividend,
  input  logic [31:0]         divisor,
  output logic                busy,
  output logic [31:0]         quotient,
  output logic [31:0]         remainder
);

  logic [31:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  count;
  logic        neg_q;
  logic        neg_r;
  logic [32:0] trial;
  logic [31:0] mag_a;
  logic [31:0] mag_b;

  // Operand magnitudes for the signed form
  always_comb begin
    mag_a = (ctl.is_signed && dividend[31]) ? (32'd0 - dividend) : dividend;
    mag_b = (ctl.is_signed && divisor[31]) ? (32'd0 - divisor) : divisor;
    trial = {rem, quo[31]} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.start) begin
      count <= 6'(msae_pkg::DivSteps);
    end else if (count != 6'd0) begin
      count <= count - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo   <= mag_a;
      dvs   <= mag_b;
      rem   <= '0;
      neg_q <= ctl.is_signed && (dividend[31] ^ divisor[31]);
      neg_r <= ctl.is_signed && dividend[31];
    end else if (count != 6'd0) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign busy      = (count != 6'd0);
  assign quotient  = neg_q ? (32'd0 - quo) : quo;
  assign remainder = neg_r ? (32'd0 - rem) : rem;

endmodule

// File: rtl/core/msae_alu.sv
`timescale 1ns / 1ps
// Combinational part: shifts, add/sub, logic, compares, moves, jumps and status codes
module msae_alu (
  input  logic [31:0] instr_word,
  input  logic [63:0] rs_value,
  input  logic [63:0] rt_value,
  input  logic [7:0]  shift_amount_reg,
  input  logic [31:0] program_counter,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  output logic        wr,
  output logic [63:0] val,
  output logic        jmp,
  output logic [1:0]  status
);

  logic [5:0]  funct;
  logic [4:0]  sa;
  logic [31:0] rs32;
  logic [31:0] rt32;

  assign funct = instr_word[5:0];
  assign sa    = instr_word[10:6];
  assign rs32  = rs_value[31:0];
  assign rt32  = rt_value[31:0];

  always_comb begin
    wr     = 1'b0;
    val    = '0;
    jmp    = 1'b0;
    status = msae_pkg::ST_OK;
    case (funct)
      msae_pkg::F_SLL:  begin wr = 1'b1; val = msae_pkg::sext32(rt32 << sa); end
      msae_pkg::F_SRL:  begin wr = 1'b1; val = msae_pkg::sext32(rt32 >> sa); end
      msae_pkg::F_SRA:  begin
        wr = 1'b1; val = msae_pkg::sext32(32'($signed(rt32) >>> sa));
      end
      msae_pkg::F_SLLV: begin
        wr = 1'b1; val = msae_pkg::sext32(rt32 << rs_value[4:0]);
      end
      msae_pkg::F_SRLV: begin
        wr = 1'b1; val = msae_pkg::sext32(rt32 >> rs_value[4:0]);
      end
      msae_pkg::F_SRAV: begin
        wr = 1'b1; val = msae_pkg::sext32(32'($signed(rt32) >>> rs_value[4:0]));
      end
      msae_pkg::F_JR:   jmp = 1'b1;
      msae_pkg::F_JALR: begin
        jmp = 1'b1; wr = 1'b1; val = msae_pkg::sext32(program_counter + 32'd8);
      end
      msae_pkg::F_MOVZ: begin wr = (rt_value == 64'd0); val = rs_value; end
      msae_pkg::F_MOVN: begin wr = (rt_value != 64'd0); val = rs_value; end
      msae_pkg::F_SYSCALL: status = msae_pkg::ST_SYSCALL;
      msae_pkg::F_SYNC: ;
      msae_pkg::F_MFHI: begin wr = 1'b1; val = hi; end
      msae_pkg::F_MFLO: begin wr = 1'b1; val = lo; end
      msae_pkg::F_DSLLV: begin wr = 1'b1; val = rt_value << rs_value[5:0]; end
      msae_pkg::F_DSRLV: begin wr = 1'b1; val = rt_value >> rs_value[5:0]; end
      msae_pkg::F_DSRAV: begin
        wr = 1'b1; val = 64'($signed(rt_value) >>> rs_value[5:0]);
      end
      msae_pkg::F_MULT, msae_pkg::F_MULTU, msae_pkg::F_DIV, msae_pkg::F_DIVU: ;
      msae_pkg::F_ADD, msae_pkg::F_ADDU: begin
        wr = 1'b1; val = msae_pkg::sext32(rs32 + rt32);
      end
      msae_pkg::F_SUB, msae_pkg::F_SUBU: begin
        wr = 1'b1; val = msae_pkg::sext32(rs32 - rt32);
      end
      msae_pkg::F_AND:  begin wr = 1'b1; val = rs_value & rt_value; end
      msae_pkg::F_OR:   begin wr = 1'b1; val = rs_value | rt_value; end
      msae_pkg::F_XOR:  begin wr = 1'b1; val = rs_value ^ rt_value; end
      msae_pkg::F_NOR:  begin wr = 1'b1; val = ~(rs_value | rt_value); end
      msae_pkg::F_MFSA: begin wr = 1'b1; val = {56'd0, shift_amount_reg}; end
      msae_pkg::F_SLT:  begin
        wr = 1'b1; val = {63'd0, ($signed(rs_value) < $signed(rt_value))};
      end
      msae_pkg::F_SLTU: begin wr = 1'b1; val = {63'd0, (rs_value < rt_value)}; end
      msae_pkg::F_DADD, msae_pkg::F_DADDU: begin wr = 1'b1; val = rs_value + rt_value; end
      msae_pkg::F_DSUB, msae_pkg::F_DSUBU: begin wr = 1'b1; val = rs_value - rt_value; end
      msae_pkg::F_DSLL:   begin wr = 1'b1; val = rt_value << sa; end
      msae_pkg::F_DSRL:   begin wr = 1'b1; val = rt_value >> sa; end
      msae_pkg::F_DSLL32: begin wr = 1'b1; val = rt_value << ({1'b0, sa} + 6'd32); end
      msae_pkg::F_DSRL32: begin wr = 1'b1; val = rt_value >> ({1'b0, sa} + 6'd32); end
      msae_pkg::F_DSRA32: begin
        wr = 1'b1; val = 64'($signed(rt_value) >>> ({1'b0, sa} + 6'd32));
      end
      default: status = msae_pkg::ST_UNKNOWN;
    endcase
  end

endmodule

// File: rtl/core/mips_special_alu_execute_core.sv
`timescale 1ns / 1ps
// SPECIAL-group execute unit for a 64-bit MIPS core.
// Input channel: in_valid/in_stall with instr_word, rs_value, rt_value,
//   shift_amount_reg and program_counter. One instruction is taken at a time;
//   in_stall is high from acceptance until its result has been transferred.
// Output channel: out_valid/out_stall with write_enable, write_reg,
//   write_value, jump_taken, jump_target and status. One result per input.
// Sequence: every item passes the decode state S_DIVFIX and ends in S_DONE,
//   where out_valid is high; mult/multu pass S_MUL in between (registered
//   32x32 multiplier) and div/divu pass S_DIV, where the radix-2 divider
//   retires one quotient bit per cycle. A divide by zero skips S_DIV.
//   No new item is taken until the result has left S_DONE.
// HI and LO live here: mult/multu/div/divu write them, mfhi/mflo read them.
// Reset clears HI, LO and the sequencer; no result is pending after reset.
// While out_stall is high the result holds and no new input is taken.
module mips_special_alu_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] instr_word,
  input  logic [63:0] rs_value,
  input  logic [63:0] rt_value,
  input  logic [7:0]  shift_amount_reg,
  input  logic [31:0] program_counter,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        write_enable,
  output logic [4:0]  write_reg,
  output logic [63:0] write_value,
  output logic        jump_taken,
  output logic [31:0] jump_target,
  output logic [1:0]  status
);

  msae_pkg::state_t   state;
  msae_pkg::state_t   state_next;
  msae_pkg::div_ctl_t div_ctl;

  logic [31:0] iw;
  logic [63:0] rsv;
  logic [63:0] rtv;
  logic [7:0]  sar;
  logic [31:0] pc;
  logic [63:0] hi;
  logic [63:0] lo;
  logic [63:0] prod;
  logic        in_xfer;
  logic        div_busy;
  logic [31:0] div_q;
  logic [31:0] div_r;
  logic        alu_wr;
  logic [63:0] alu_val;
  logic        alu_jmp;
  logic [1:0]  alu_status;
  logic [5:0]  funct;
  logic        is_mul;
  logic        is_div;
  logic        div_zero;

  assign funct    = iw[5:0];
  assign is_mul   = (funct == msae_pkg::F_MULT) || (funct == msae_pkg::F_MULTU);
  assign is_div   = (funct == msae_pkg::F_DIV) || (funct == msae_pkg::F_DIVU);
  assign div_zero = (rtv[31:0] == 32'd0);
  assign in_stall = (state != msae_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // Capture the item
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      iw  <= instr_word;
      rsv <= rs_value;
      rtv <= rt_value;
      sar <= shift_amount_reg;
      pc  <= program_counter;
    end
  end

  // Registered multiplier, signed or unsigned on 33-bit extended operands
  always_ff @(posedge clk) begin
    prod <= 64'($signed({(funct == msae_pkg::F_MULT) & rsv[31], rsv[31:0]}) *
                $signed({(funct == msae_pkg::F_MULT) & rtv[31], rtv[31:0]}));
  end

  msae_alu u_alu (
    .instr_word       (iw),
    .rs_value         (rsv),
    .rt_value         (rtv),
    .shift_amount_reg (sar),
    .program_counter  (pc),
    .hi               (hi),
    .lo               (lo),
    .wr               (alu_wr),
    .val              (alu_val),
    .jmp              (alu_jmp),
    .status           (alu_status)
  );

  msae_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctl       (div_ctl),
    .dividend  (rsv[31:0]),
    .divisor   (rtv[31:0]),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msae_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next        = state;
    div_ctl.start     = 1'b0;
    div_ctl.is_signed = (funct == msae_pkg::F_DIV);
    case (state)
      msae_pkg::S_IDLE: begin
        if (in_xfer) state_next = msae_pkg::S_DIVFIX;
      end
      // S_DIVFIX from idle acts as the decode cycle
      msae_pkg::S_DIVFIX: begin
        if (is_mul) begin
          state_next = msae_pkg::S_MUL;
        end else if (is_div && !div_zero && !div_busy) begin
          div_ctl.start = 1'b1;
          state_next    = msae_pkg::S_DIV;
        end else begin
          state_next = msae_pkg::S_DONE;
        end
      end
      msae_pkg::S_MUL: state_next = msae_pkg::S_DONE;
      msae_pkg::S_DIV: begin
        if (!div_busy) state_next = msae_pkg::S_DONE;
      end
      msae_pkg::S_DONE: begin
        if (!out_stall) state_next = msae_pkg::S_IDLE;
      end
      default: state_next = msae_pkg::S_IDLE;
    endcase
  end

  // HI/LO and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hi        <= '0;
      lo        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == msae_pkg::S_DONE && !out_stall) out_valid <= 1'b0;
      if (state == msae_pkg::S_MUL) begin
        lo <= msae_pkg::sext32(prod[31:0]);
        hi <= msae_pkg::sext32(prod[63:32]);
      end
      if (state == msae_pkg::S_DIV && !div_busy) begin
        lo <= msae_pkg::sext32(div_q);
        hi <= msae_pkg::sext32(div_r);
      end
      if (state_next == msae_pkg::S_DONE && state != msae_pkg::S_DONE) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_next == msae_pkg::S_DONE && state != msae_pkg::S_DONE) begin
      write_reg   <= iw[15:11];
      jump_taken  <= alu_jmp;
      jump_target <= alu_jmp ? rsv[31:0] : 32'd0;
      if (is_mul) begin
        write_enable <= (iw[15:11] != 5'd0);
        write_value  <= (iw[15:11] != 5'd0) ? msae_pkg::sext32(prod[31:0]) : 64'd0;
        status       <= msae_pkg::ST_OK;
      end else if (is_div) begin
        write_enable <= 1'b0;
        write_value  <= '0;
        status       <= div_zero ? msae_pkg::ST_DIVZERO : msae_pkg::ST_OK;
      end else begin
        write_enable <= alu_wr && (iw[15:11] != 5'd0);
        write_value  <= (alu_wr && (iw[15:11] != 5'd0)) ? alu_val : 64'd0;
        status       <= alu_status;
      end
    end
  end

`ifndef SYNTHESIS
  // Output valid only while the sequencer is in its done state
  a_valid_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == msae_pkg::S_DONE))
    else $error("out_valid outside done state");

  // Register zero is never written
  a_no_r0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_reg == 5'd0) |-> !write_enable)
    else $error("write to register zero");

  // The divider is only started when idle
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_busy)
    else $error("divider restarted while busy");

  // A divide-by-zero never writes
  a_dz: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == msae_pkg::ST_DIVZERO) |-> !write_enable)
    else $error("write on divide by zero");
`endif

endmodule
